### rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and tables for the quaternion to Euler converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int COMPONENT_BITS_DEF      = 16;
    localparam int CORDIC_STEPS_DEF        = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 7;

    localparam int WORK_FRAC     = 30;
    localparam int ANG_UNIT_BITS = 16;
    localparam int TABLE_LEN     = 24;

    // vector coordinates: |v| <= 4 * 2^30 before growth, CORDIC gain < 1.65
    localparam int VW = 36;
    // angle accumulator, 2^-16 degree
    localparam int AW = 26;
    // square-root radicand, 60 fraction bits
    localparam int RW = 62;

    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W   = 16;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [AW-1:0] t_ang;

    // one CORDIC lane
    typedef struct packed {
        t_vec x;
        t_vec y;
        t_ang z;
        logic zero;
    } t_lane;

    function automatic t_ang atan_entry(input int i);
        t_ang r;
        r = '0;
        case (i)
            0:  r = AW'(2949120);
            1:  r = AW'(1740967);
            2:  r = AW'(919879);
            3:  r = AW'(466945);
            4:  r = AW'(234379);
            5:  r = AW'(117304);
            6:  r = AW'(58666);
            7:  r = AW'(29335);
            8:  r = AW'(14668);
            9:  r = AW'(7334);
            10: r = AW'(3667);
            11: r = AW'(1833);
            12: r = AW'(917);
            13: r = AW'(458);
            14: r = AW'(229);
            15: r = AW'(115);
            16: r = AW'(57);
            17: r = AW'(29);
            18: r = AW'(14);
            19: r = AW'(7);
            20: r = AW'(4);
            21: r = AW'(2);
            22: r = AW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/quaternion_to_euler_degrees.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees
// Quaternion to roll, pitch, yaw in 2^-ANGLE_FRACTION_BITS degree.
// ----------------------------------------------------------------------------
// channel | dir | word
// s_axis  | in  | tdata: quat_x, quat_y, quat_z, quat_w
// m_axis  | out | tdata: roll_deg, pitch_deg, yaw_deg
//
// One word per cycle while the output is not stalled. Registered steps in order: product,
// sum, 31 square-root cells, prerotation, CORDIC cells, rounding.
// The whole chain advances when the output register is free or being taken.
// Reset clears valid bits only.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees #(
    parameter int COMPONENT_BITS      = q2e_pkg::COMPONENT_BITS_DEF,
    parameter int CORDIC_STEPS        = q2e_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = q2e_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w from bit 0 up
    input  logic [4*COMPONENT_BITS-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // roll_deg[15:0], pitch_deg[30:16], yaw_deg[46:31], zero fill
    output logic [47:0]                   m_axis_tdata
);
    import q2e_pkg::*;

    localparam int CB    = COMPONENT_BITS;
    localparam int PF    = 2 * (CB - 1);
    localparam int NS    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int NSQ   = 31;
    localparam int DEPTH = 2 + NSQ + 1 + NS + 1;
    localparam int SH    = ANG_UNIT_BITS - ANGLE_FRACTION_BITS;
    localparam logic signed [VW-1:0] ONE = VW'(1) <<< WORK_FRAC;

    logic en;
    logic [DEPTH-1:0] r_vld;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // ---- stage 1: products
    logic signed [CB-1:0] qx, qy, qz, qw;
    assign qx = s_axis_tdata[0*CB +: CB];
    assign qy = s_axis_tdata[1*CB +: CB];
    assign qz = s_axis_tdata[2*CB +: CB];
    assign qw = s_axis_tdata[3*CB +: CB];

    logic signed [2*CB-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= qw * qx;  r_yz <= qy * qz;  r_xx <= qx * qx;
            r_yy <= qy * qy;  r_wy <= qw * qy;  r_zx <= qz * qx;
            r_wz <= qw * qz;  r_xy <= qx * qy;  r_zz <= qz * qz;
        end
    end

    function automatic t_vec scl(input logic signed [2*CB-1:0] p);
        logic signed [VW+2*CB-1:0] e;
        e = (VW+2*CB)'(p);
        if (PF >= WORK_FRAC) return VW'(e >>> (PF - WORK_FRAC));
        else return VW'(e <<< (WORK_FRAC - PF));
    endfunction

    // ---- stage 2: sums, clamp, radicand
    t_vec n_t0, n_t1, n_t2, n_t3, n_t4;
    logic [RW-1:0] n_rad;
    // clamped sine fits in 32 bits
    logic signed [31:0] t2_lo;
    logic signed [63:0] sq;

    always_comb begin
        n_t0 = (scl(r_wx) + scl(r_yz)) <<< 1;
        n_t1 = ONE - ((scl(r_xx) + scl(r_yy)) <<< 1);
        n_t2 = (scl(r_wy) - scl(r_zx)) <<< 1;
        if (n_t2 > ONE)  n_t2 = ONE;
        if (n_t2 < -ONE) n_t2 = -ONE;
        n_t3 = (scl(r_wz) + scl(r_xy)) <<< 1;
        n_t4 = ONE - ((scl(r_yy) + scl(r_zz)) <<< 1);
        t2_lo = n_t2[31:0];
        sq    = t2_lo * t2_lo;
        n_rad = (RW'(1) << 60) - RW'(sq);
    end

    function automatic t_lane mk(input t_vec y, input t_vec x);
        t_lane l;
        l.y = y; l.x = x; l.z = '0;
        l.zero = (x == '0) && (y == '0);
        return l;
    endfunction

    logic [RW-1:0]  sq_rem [NSQ+1];
    logic [RW-1:0]  sq_res [NSQ+1];
    t_vec           sq_sin [NSQ+1];
    t_lane          sq_a   [NSQ+1];
    t_lane          sq_b   [NSQ+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            sq_rem[0] <= n_rad;
            sq_res[0] <= '0;
            sq_sin[0] <= n_t2;
            sq_a[0]   <= mk(n_t0, n_t1);
            sq_b[0]   <= mk(n_t3, n_t4);
        end
    end

    // ---- square-root chain
    genvar g;
    generate
        for (g = 0; g < NSQ; g++) begin : g_sq
            q2e_sqrt_cell #(.STEP(g)) u_cell (
                .i_clk(i_clk), .i_en(en),
                .i_rem(sq_rem[g]), .i_res(sq_res[g]), .i_sin(sq_sin[g]),
                .i_a(sq_a[g]), .i_b(sq_b[g]),
                .o_rem(sq_rem[g+1]), .o_res(sq_res[g+1]), .o_sin(sq_sin[g+1]),
                .o_a(sq_a[g+1]), .o_b(sq_b[g+1])
            );
        end
    endgenerate

    // ---- prerotation
    function automatic t_lane pre(input t_lane l);
        t_lane o;
        o = l;
        if (l.x[VW-1]) begin
            if (!l.y[VW-1]) begin
                o.x = l.y; o.y = -l.x; o.z = AW'(90 <<< ANG_UNIT_BITS);
            end else begin
                o.x = -l.y; o.y = l.x; o.z = -AW'(90 <<< ANG_UNIT_BITS);
            end
        end
        return o;
    endfunction

    t_lane cl [3][NS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            cl[0][0] <= pre(sq_a[NSQ]);
            cl[1][0] <= pre(mk(sq_sin[NSQ], VW'(sq_res[NSQ])));
            cl[2][0] <= pre(sq_b[NSQ]);
        end
    end

    genvar l;
    generate
        for (l = 0; l < 3; l++) begin : g_lane
            for (g = 0; g < NS; g++) begin : g_step
                q2e_cordic_cell #(.STEP(g)) u_cell (
                    .i_clk(i_clk), .i_en(en),
                    .i_lane(cl[l][g]), .o_lane(cl[l][g+1])
                );
            end
        end
    endgenerate

    // ---- rounding and clamp
    function automatic logic signed [AW-1:0] outc(input t_lane ln, input int lim_deg);
        logic signed [AW-1:0] r, lim;
        lim = AW'(lim_deg) <<< ANGLE_FRACTION_BITS;
        if (ln.zero) return '0;
        if (SH > 0) r = (ln.z + (AW'(1) <<< (SH - 1))) >>> SH;
        else r = ln.z;
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    logic signed [AW-1:0] ro, po, yo;
    assign ro = outc(cl[0][NS], 180);
    assign po = outc(cl[1][NS], 90);
    assign yo = outc(cl[2][NS], 180);

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= {1'b0, yo[YAW_W-1:0], po[PITCH_W-1:0], ro[ROLL_W-1:0]};
        end
    end

endmodule

### rtl/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One registered digit step of a non-restoring-free integer square root.
// Carries the pitch sine and the roll/yaw lanes alongside.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [q2e_pkg::RW-1:0]     i_rem,
    input  logic [q2e_pkg::RW-1:0]     i_res,
    input  q2e_pkg::t_vec              i_sin,
    input  q2e_pkg::t_lane             i_a,
    input  q2e_pkg::t_lane             i_b,
    output logic [q2e_pkg::RW-1:0]     o_rem,
    output logic [q2e_pkg::RW-1:0]     o_res,
    output q2e_pkg::t_vec              o_sin,
    output q2e_pkg::t_lane             o_a,
    output q2e_pkg::t_lane             o_b
);
    import q2e_pkg::*;

    localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2 * STEP);

    logic [RW-1:0] n_rem, n_res;

    always_comb begin
        if (i_rem >= i_res + BIT) begin
            n_rem = i_rem - (i_res + BIT);
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_rem = i_rem;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_res <= n_res;
            o_sin <= i_sin;
            o_a   <= i_a;
            o_b   <= i_b;
        end
    end

endmodule

### rtl/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One registered vectoring CORDIC iteration on a single lane.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  q2e_pkg::t_lane  i_lane,
    output q2e_pkg::t_lane  o_lane
);
    import q2e_pkg::*;

    t_lane n_lane;
    t_vec  xs, ys;

    always_comb begin
        xs = i_lane.x >>> STEP;
        ys = i_lane.y >>> STEP;
        n_lane = i_lane;
        if (!i_lane.y[VW-1]) begin
            n_lane.x = i_lane.x + ys;
            n_lane.y = i_lane.y - xs;
            n_lane.z = i_lane.z + atan_entry(STEP);
        end else begin
            n_lane.x = i_lane.x - ys;
            n_lane.y = i_lane.y + xs;
            n_lane.z = i_lane.z - atan_entry(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lane <= n_lane;
        end
    end

endmodule

### rtl/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks for the quaternion to Euler converter.
// ----------------------------------------------------------------------------
module q2e_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped or changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output blocked");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47] == 1'b0)
        else $error("fill bit set");

endmodule

bind quaternion_to_euler_degrees q2e_checker u_q2e_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
